/* hw/rtl/vcf_gac_pkg.sv */
// Package with constants and types shared by the VCF genotype allele caller.
`default_nettype none
package vcf_gac_pkg;
    localparam int unsigned DEF_MAX_SAMPLES = 1024;
    localparam int unsigned DEF_COUNT_BITS = 16;
    localparam int unsigned DEF_MAX_FORMAT_KEYS = 15;
    localparam logic [15:0] MIN_COVERAGE_RESET = 16'd10;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [10:0] COL_REF = 11'd3;
    localparam logic [10:0] COL_ALT = 11'd4;
    localparam logic [10:0] COL_FORMAT = 11'd8;
    localparam logic [10:0] COL_FIRST_SAMPLE = 11'd9;
    localparam logic [10:0] COL_MAX = 11'd2047;

    typedef enum logic [1:0] {
        NUM_IDLE = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE = 2'd2
    } num_state_t;
endpackage
`default_nettype wire

/* hw/rtl/vcf_genotype_allele_caller_top.sv */
// Top level of the VCF genotype allele caller: byte parser and per-sample call.
`default_nettype none
// Usage: the block takes one text byte per cycle and reaches one byte per clock when
// out_ready stays high. Each byte passes through a state update and, at the end of a
// sample column, the call is computed from the column registers into a result
// register; the only limit on rate is the single-entry result register, which frees
// in the same cycle it is taken. Header lines starting with '#' produce no beats.
// The min_coverage register may be written only while the block is idle.
module vcf_genotype_allele_caller_top #(
    parameter int unsigned MAX_SAMPLES = vcf_gac_pkg::DEF_MAX_SAMPLES,
    parameter int unsigned COUNT_BITS = vcf_gac_pkg::DEF_COUNT_BITS,
    parameter int unsigned MAX_FORMAT_KEYS = vcf_gac_pkg::DEF_MAX_FORMAT_KEYS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [9:0]       sample_index,
    output logic [7:0]       first_allele,
    output logic [7:0]       second_allele,
    output logic             end_of_row
);
    import vcf_gac_pkg::*;

    localparam int KB = 5;
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS + 1 : 17;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [KB-1:0] MAXK = KB'(MAX_FORMAT_KEYS);

    logic [15:0] cov_reg;
    logic [10:0] col_reg, col_next;
    logic hdr_reg, hdr_next, start_reg, start_next;
    logic [7:0] refb_reg, refb_next, altb_reg, altb_next;
    logic [1:0] refl_reg, refl_next, altl_reg, altl_next;
    logic [KB-1:0] dpk_reg, dpk_next, adk_reg, adk_next, fcc_reg, fcc_next;
    logic [17:0] key_reg, key_next;
    logic [4:0] sub_reg, sub_next;
    logic [1:0] comma_reg, comma_next;
    logic [COUNT_BITS-1:0] dp_reg, dp_next, rc_reg, rc_next, ac_reg, ac_next;
    logic seen_reg, seen_next, bytes_reg, bytes_next;
    num_state_t num_reg, num_next;
    logic emit;
    logic [9:0] o_idx;
    logic [7:0] o_a1, o_a2;
    logic o_last;

    assign cfg_ready = 1'b1;
    assign in_ready = !out_valid || out_ready;
    wire take = in_valid && in_ready;

    function automatic logic [COUNT_BITS-1:0] acc_digit(
        input logic [COUNT_BITS-1:0] acc, input logic [7:0] b);
        logic [COUNT_BITS+4:0] v;
        begin
            v = {5'd0, acc} * (COUNT_BITS+5)'(10) + (COUNT_BITS+5)'(b - CH_ZERO);
            acc_digit = (v > {5'd0, CMAX}) ? CMAX : v[COUNT_BITS-1:0];
        end
    endfunction

    always_comb
    begin
        logic [7:0] b;
        logic [10:0] col;
        logic [1:0] len;
        logic [KB:0] pos;
        logic inc, ind, dig, last;
        logic [KB-1:0] colons;
        logic [CW-1:0] c1, c2;
        logic [7:0] r, a;
        b = text_byte;
        col_next = col_reg; hdr_next = hdr_reg; start_next = start_reg;
        refb_next = refb_reg; refl_next = refl_reg; altb_next = altb_reg;
        altl_next = altl_reg; dpk_next = dpk_reg; adk_next = adk_reg;
        fcc_next = fcc_reg; key_next = key_reg; sub_next = sub_reg;
        comma_next = comma_reg; dp_next = dp_reg; rc_next = rc_reg; ac_next = ac_reg;
        seen_next = seen_reg; num_next = num_reg; bytes_next = bytes_reg;
        emit = 1'b0; o_idx = '0; o_a1 = CH_N; o_a2 = CH_N; o_last = 1'b0;
        len = '0; pos = '0; inc = 1'b0; ind = 1'b0; colons = '0;
        c1 = '0; c2 = '0; r = '0; a = '0; last = 1'b0;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        if (start_reg)
        begin
            start_next = 1'b0; col_next = '0; hdr_next = (b == CH_HASH);
            refb_next = '0; refl_next = '0; altb_next = '0; altl_next = '0;
            dpk_next = '0; adk_next = '0; fcc_next = '0;
            key_next = '0; sub_next = '0; comma_next = '0; dp_next = '0;
            rc_next = '0; ac_next = '0; seen_next = 1'b0; num_next = NUM_IDLE;
            bytes_next = 1'b0;
        end
        col = col_next;
        if (hdr_next)
        begin
            if (b == CH_NL)
            begin
                start_next = 1'b1; hdr_next = 1'b0;
            end
        end
        else if (b == CH_TAB || b == CH_NL)
        begin
            last = (b == CH_NL);
            if (col == COL_ALT)
            begin
                if (refl_next != 2'd1)
                begin
                    refb_next = CH_N; altb_next = CH_N;
                end
                else if (altl_next > 2'd1)
                    altb_next = CH_N;
                if (refb_next == CH_N) altb_next = CH_N;
                if (altb_next == CH_DOT) altb_next = refb_next;
            end
            if (col == COL_FORMAT && key_next[17:16] == 2'd2 && sub_next < MAXK)
            begin
                if (key_next[7:0] == CH_D && key_next[15:8] == CH_P)
                    dpk_next = sub_next + 1'b1;
                if (key_next[7:0] == CH_A && key_next[15:8] == CH_D)
                    adk_next = sub_next + 1'b1;
            end
            if (col >= COL_FIRST_SAMPLE && !(last && !bytes_next)
                && 32'(col - COL_FIRST_SAMPLE) < MAX_SAMPLES)
            begin
                emit = 1'b1; o_idx = 10'(col - COL_FIRST_SAMPLE); o_last = last;
                colons = (sub_next > MAXK) ? MAXK : sub_next;
                r = refb_next; a = altb_next;
                c1 = CW'(cov_reg); c2 = CW'({cov_reg, 1'b0});
                if (r != CH_N && a != CH_N && colons == fcc_next)
                begin
                    priority if (!seen_next)
                    begin
                        if (CW'(dp_next) >= c1)
                        begin
                            o_a1 = r; o_a2 = (CW'(dp_next) < c2) ? CH_N : r;
                        end
                    end
                    else if (CW'(rc_next) >= c1)
                    begin
                        o_a1 = r;
                        if (CW'(ac_next) >= c1) o_a2 = a;
                        else o_a2 = (CW'(rc_next) < c2) ? CH_N : r;
                    end
                    else if (CW'(ac_next) >= c1)
                    begin
                        o_a1 = a; o_a2 = (CW'(ac_next) < c2) ? CH_N : a;
                    end
                    else
                    begin
                        o_a1 = CH_N; o_a2 = CH_N;
                    end
                end
            end
            if (last) start_next = 1'b1;
            else if (col < COL_MAX) col_next = col + 1'b1;
            key_next = '0; sub_next = '0; comma_next = '0; dp_next = '0;
            rc_next = '0; ac_next = '0; seen_next = 1'b0; num_next = NUM_IDLE;
            bytes_next = 1'b0;
        end
        else
        begin
            bytes_next = 1'b1;
            if (col == COL_REF)
            begin
                if (refl_next == 2'd0) refb_next = b;
                if (refl_next < 2'd3) refl_next = refl_next + 1'b1;
            end
            else if (col == COL_ALT)
            begin
                if (altl_next == 2'd0) altb_next = b;
                if (altl_next < 2'd3) altl_next = altl_next + 1'b1;
            end
            else if (col == COL_FORMAT)
            begin
                if (b == CH_COLON)
                begin
                    if (key_next[17:16] == 2'd2 && sub_next < MAXK)
                    begin
                        if (key_next[7:0] == CH_D && key_next[15:8] == CH_P)
                            dpk_next = sub_next + 1'b1;
                        if (key_next[7:0] == CH_A && key_next[15:8] == CH_D)
                            adk_next = sub_next + 1'b1;
                    end
                    key_next = '0;
                    if (sub_next < 5'd31) sub_next = sub_next + 1'b1;
                    if (fcc_next < MAXK) fcc_next = fcc_next + 1'b1;
                end
                else
                begin
                    len = key_next[17:16];
                    if (len == 2'd0) key_next[7:0] = b;
                    else if (len == 2'd1) key_next[15:8] = b;
                    if (len < 2'd3) key_next[17:16] = len + 1'b1;
                end
            end
            else if (col >= COL_FIRST_SAMPLE)
            begin
                pos = {1'b0, sub_next} + 1'b1;
                inc = (adk_next != '0) && (pos == {1'b0, adk_next});
                ind = (dpk_next != '0) && (pos == {1'b0, dpk_next});
                if (b == CH_COLON)
                begin
                    if (inc) seen_next = 1'b1;
                    if (sub_next < 5'd31) sub_next = sub_next + 1'b1;
                    num_next = NUM_IDLE; comma_next = '0;
                end
                else if (inc)
                begin
                    seen_next = 1'b1;
                    if (b == CH_COMMA)
                    begin
                        if (comma_next < 2'd2) comma_next = comma_next + 1'b1;
                        num_next = NUM_IDLE;
                    end
                    else if (comma_next != 2'd2 && num_next != NUM_DONE)
                    begin
                        if (!dig) num_next = NUM_DONE;
                        else if (comma_next == 2'd0)
                        begin
                            rc_next = (num_next == NUM_IDLE)
                                ? COUNT_BITS'(b - CH_ZERO) : acc_digit(rc_next, b);
                            num_next = NUM_DIGITS;
                        end
                        else
                        begin
                            ac_next = (num_next == NUM_IDLE)
                                ? COUNT_BITS'(b - CH_ZERO) : acc_digit(ac_next, b);
                            num_next = NUM_DIGITS;
                        end
                    end
                end
                else if (ind && num_next != NUM_DONE)
                begin
                    if (!dig) num_next = NUM_DONE;
                    else
                    begin
                        dp_next = (num_next == NUM_IDLE)
                            ? COUNT_BITS'(b - CH_ZERO) : acc_digit(dp_next, b);
                        num_next = NUM_DIGITS;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cov_reg <= MIN_COVERAGE_RESET;
            col_reg <= '0; hdr_reg <= 1'b0; start_reg <= 1'b1;
            refb_reg <= '0; refl_reg <= '0; altb_reg <= '0; altl_reg <= '0;
            dpk_reg <= '0; adk_reg <= '0; fcc_reg <= '0; key_reg <= '0;
            sub_reg <= '0; comma_reg <= '0; dp_reg <= '0; rc_reg <= '0;
            ac_reg <= '0; seen_reg <= 1'b0; num_reg <= NUM_IDLE; bytes_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid) cov_reg <= cfg_data;
            if (take)
            begin
                col_reg <= col_next; hdr_reg <= hdr_next; start_reg <= start_next;
                refb_reg <= refb_next; refl_reg <= refl_next;
                altb_reg <= altb_next; altl_reg <= altl_next;
                dpk_reg <= dpk_next; adk_reg <= adk_next; fcc_reg <= fcc_next;
                key_reg <= key_next; sub_reg <= sub_next; comma_reg <= comma_next;
                dp_reg <= dp_next; rc_reg <= rc_next; ac_reg <= ac_next;
                seen_reg <= seen_next; num_reg <= num_next; bytes_reg <= bytes_next;
            end
            if (take) out_valid <= emit;
            else if (out_ready) out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            sample_index <= o_idx; first_allele <= o_a1;
            second_allele <= o_a2; end_of_row <= o_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_index))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input blocked with empty output");
    a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_reg && !start_reg |-> !emit) else $error("call from a header line");
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit && o_last |=> start_reg) else $error("row end without line reset");
`endif
endmodule
`default_nettype wire

/* bench/vcf_genotype_allele_caller_top_tb.sv */
// VCF genotype allele caller self-checking bench: fixed and random text in, per-sample calls out.
`default_nettype none
module vcf_genotype_allele_caller_top_tb;
    import vcf_gac_pkg::*;

    localparam int unsigned MAXS = DEF_MAX_SAMPLES;
    localparam int unsigned MAXK = DEF_MAX_FORMAT_KEYS;
    localparam int unsigned CNT_MAX = (1 << DEF_COUNT_BITS) - 1;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic [9:0] sample_index;
        logic [7:0] first_allele;
        logic [7:0] second_allele;
        logic       end_of_row;
    } sample_call_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        out_valid;
    logic        out_ready;
    logic [9:0]  sample_index;
    logic [7:0]  first_allele;
    logic [7:0]  second_allele;
    logic        end_of_row;

    vcf_genotype_allele_caller_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
        .out_valid(out_valid), .out_ready(out_ready), .sample_index(sample_index),
        .first_allele(first_allele), .second_allele(second_allele),
        .end_of_row(end_of_row)
    );

    logic [7:0]   pending_bytes[$];
    sample_call_t expected_calls[$];
    int unsigned  error_count;
    int unsigned  idle_cycles;
    bit           calm;
    bit           in_taken;

    // Caller state, mirrored.
    logic [15:0] min_cov;
    int unsigned col_num;
    bit          hdr_line;
    bit          line_start;
    int unsigned ref_b, ref_len, alt_b, alt_len;
    int unsigned dp_pos, ad_pos, fmt_colons;
    int unsigned key_c0, key_c1, key_len;
    int unsigned sub_num, comma_num;
    int unsigned dp_val, ref_cnt, alt_cnt;
    bit          ad_seen;
    num_state_t  num_st;
    bit          col_bytes;

    function automatic void clear_column_state();
        key_c0 = 0; key_c1 = 0; key_len = 0; sub_num = 0; comma_num = 0;
        dp_val = 0; ref_cnt = 0; alt_cnt = 0; ad_seen = 0; num_st = NUM_IDLE;
        col_bytes = 0;
    endfunction

    function automatic void clear_line_state();
        col_num = 0; hdr_line = 0; ref_b = 0; ref_len = 0; alt_b = 0; alt_len = 0;
        dp_pos = 0; ad_pos = 0; fmt_colons = 0;
        clear_column_state();
    endfunction

    function automatic void reset_caller();
        min_cov = MIN_COVERAGE_RESET;
        clear_line_state();
        line_start = 1;
    endfunction

    function automatic int unsigned accumulate(int unsigned acc, logic [7:0] b);
        longint unsigned v;
        if (num_st == NUM_DONE)
            return acc;
        if (!(b >= CH_ZERO && b <= CH_NINE)) begin
            num_st = NUM_DONE;
            return acc;
        end
        if (num_st == NUM_IDLE) begin
            num_st = NUM_DIGITS;
            return b - CH_ZERO;
        end
        v = longint'(acc) * 10 + (b - CH_ZERO);
        return (v > CNT_MAX) ? CNT_MAX : 32'(v);
    endfunction

    function automatic void close_format_key();
        int unsigned p;
        p = sub_num + 1;
        if (key_len != 2 || p > MAXK)
            return;
        if (key_c0 == CH_D && key_c1 == CH_P) dp_pos = p;
        if (key_c0 == CH_A && key_c1 == CH_D) ad_pos = p;
    endfunction

    function automatic void genotype(output logic [7:0] a1, output logic [7:0] a2);
        longint unsigned c, c2;
        int unsigned colons;
        c = min_cov;
        c2 = 2 * c;
        colons = (sub_num > MAXK) ? MAXK : sub_num;
        a1 = CH_N; a2 = CH_N;
        if (ref_b == CH_N || alt_b == CH_N || colons != fmt_colons)
            return;
        if (!ad_seen) begin
            if (dp_val < c)
                return;
            a1 = 8'(ref_b);
            a2 = (dp_val < c2) ? CH_N : 8'(ref_b);
        end else if (ref_cnt >= c) begin
            a1 = 8'(ref_b);
            if (alt_cnt >= c) a2 = 8'(alt_b);
            else a2 = (ref_cnt < c2) ? CH_N : 8'(ref_b);
        end else if (alt_cnt >= c) begin
            a1 = 8'(alt_b);
            a2 = (alt_cnt < c2) ? CH_N : 8'(alt_b);
        end
    endfunction

    function automatic void close_column(bit last);
        sample_call_t r;
        if (col_num == COL_ALT) begin
            if (ref_len != 1) begin
                ref_b = CH_N; alt_b = CH_N;
            end else if (alt_len > 1) alt_b = CH_N;
            if (ref_b == CH_N) alt_b = CH_N;
            if (alt_b == CH_DOT) alt_b = ref_b;
        end
        if (col_num == COL_FORMAT) close_format_key();
        if (col_num < COL_FIRST_SAMPLE || (last && !col_bytes) || col_num - 9 >= MAXS)
            return;
        genotype(r.first_allele, r.second_allele);
        r.sample_index = 10'(col_num - 9);
        r.end_of_row = last;
        expected_calls.insert(expected_calls.size(), r);
    endfunction

    function automatic void sample_char(logic [7:0] b);
        int unsigned p;
        bit in_ad, in_dp;
        p = sub_num + 1;
        in_ad = (ad_pos != 0 && p == ad_pos);
        in_dp = (dp_pos != 0 && p == dp_pos);
        if (b == CH_COLON) begin
            if (in_ad) ad_seen = 1;
            if (sub_num < 31) sub_num++;
            num_st = NUM_IDLE; comma_num = 0;
        end else if (in_ad) begin
            ad_seen = 1;
            if (b == CH_COMMA) begin
                if (comma_num < 2) comma_num++;
                num_st = NUM_IDLE;
            end else if (comma_num == 0) ref_cnt = accumulate(ref_cnt, b);
            else if (comma_num == 1) alt_cnt = accumulate(alt_cnt, b);
        end else if (in_dp) dp_val = accumulate(dp_val, b);
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        if (line_start) begin
            line_start = 0;
            clear_line_state();
            if (b == CH_HASH) hdr_line = 1;
        end
        if (hdr_line) begin
            if (b == CH_NL) begin
                line_start = 1; hdr_line = 0;
            end
            return;
        end
        if (b == CH_TAB || b == CH_NL) begin
            close_column(b == CH_NL);
            if (b == CH_NL) line_start = 1;
            else if (col_num < COL_MAX) col_num++;
            clear_column_state();
            return;
        end
        col_bytes = 1;
        if (col_num == COL_REF) begin
            if (ref_len == 0) ref_b = b;
            if (ref_len < 3) ref_len++;
        end else if (col_num == COL_ALT) begin
            if (alt_len == 0) alt_b = b;
            if (alt_len < 3) alt_len++;
        end else if (col_num == COL_FORMAT) begin
            if (b == CH_COLON) begin
                close_format_key();
                key_c0 = 0; key_c1 = 0; key_len = 0;
                if (sub_num < 31) sub_num++;
                if (fmt_colons < MAXK) fmt_colons++;
            end else begin
                if (key_len == 0) key_c0 = b;
                else if (key_len == 1) key_c1 = b;
                if (key_len < 3) key_len++;
            end
        end else if (col_num >= COL_FIRST_SAMPLE) sample_char(b);
    endfunction

    // Text building.
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.insert(pending_bytes.size(), s[i]);
    endfunction

    function automatic string rand_number();
        case ($urandom_range(0, 9))
            0: return "";
            1: return ".";
            2: return "99999999";
            3: return "-5";
            default: return $sformatf("%0d", $urandom_range(0, 45));
        endcase
    endfunction

    function automatic string rand_base();
        string bases;
        bases = "ACGT";
        case ($urandom_range(0, 9))
            0: return "N";
            1: return "AC";
            2: return "";
            3: return ".";
            4: return "GTTA";
            default: return bases.substr($urandom_range(0, 3), $urandom_range(0, 3));
        endcase
    endfunction

    function automatic string rand_noise(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'($urandom_range(0, 255)))};
        return s;
    endfunction

    function automatic void put_record();
        string s, fmt, smp;
        int nk, ns;
        string keys[$];
        if ($urandom_range(0, 12) == 0) begin
            put_text({"#", rand_noise($urandom_range(0, 6)), "\n"});
            return;
        end
        if ($urandom_range(0, 15) == 0) begin
            put_text({rand_noise($urandom_range(1, 12)), "\n"});
            return;
        end
        nk = $urandom_range(1, 4);
        keys.delete();
        for (int k = 0; k < nk; k++)
            case ($urandom_range(0, 3))
                0: keys.insert(keys.size(), "GT");
                1: keys.insert(keys.size(), "DP");
                2: keys.insert(keys.size(), "AD");
                default: keys.insert(keys.size(), "GQ");
            endcase
        fmt = keys[0];
        for (int k = 1; k < nk; k++)
            fmt = {fmt, ":", keys[k]};
        s = {"c\t", $sformatf("%0d", $urandom_range(1, 999)), "\t.\t", rand_base(), "\t",
             rand_base(), "\t.\t.\t.\t", fmt};
        ns = $urandom_range(1, 3);
        for (int j = 0; j < ns; j++) begin
            int fields;
            fields = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : nk;
            smp = "";
            for (int k = 0; k < fields; k++) begin
                string f;
                if (k < nk && keys[k] == "AD")
                    f = {rand_number(), ",", rand_number(),
                         ($urandom_range(0, 5) == 0) ? ",7" : ""};
                else if (k < nk && keys[k] == "GT")
                    f = "0/1";
                else
                    f = rand_number();
                smp = (k == 0) ? f : {smp, ":", f};
            end
            s = {s, "\t", smp};
        end
        if ($urandom_range(0, 9) == 0) s = {s, "\t"};
        put_text({s, "\n"});
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Driver.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
        end else begin
            if (!in_valid || in_taken) begin
                if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                    in_valid <= 1;
                    text_byte <= pending_bytes.pop_front();
                end else begin
                    in_valid <= 0;
                end
            end
            out_ready <= calm || $urandom_range(0, 99) >= 17;
        end
    end

    // Monitor and watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("vcf_genotype_allele_caller_top regression: fail");
                $finish;
            end
        end
    end

    always @(posedge clk) begin
        sample_call_t got, want;
        if (!rst_n) begin
            in_taken <= 0;
        end else begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                predict_byte(text_byte);
        end
        if (rst_n && out_valid && out_ready) begin
            got = '{sample_index, first_allele, second_allele, end_of_row};
            if (expected_calls.size() == 0) begin
                $display("%0t: unexpected call, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = expected_calls.pop_front();
                if (got.sample_index !== want.sample_index) begin
                    $display("%0t: sample_index expected %0d actual %0d", $time,
                             want.sample_index, got.sample_index);
                    error_count++;
                end
                if (got.first_allele !== want.first_allele) begin
                    $display("%0t: first_allele expected %h actual %h", $time,
                             want.first_allele, got.first_allele);
                    error_count++;
                end
                if (got.second_allele !== want.second_allele) begin
                    $display("%0t: second_allele expected %h actual %h", $time,
                             want.second_allele, got.second_allele);
                    error_count++;
                end
                if (got.end_of_row !== want.end_of_row) begin
                    $display("%0t: end_of_row expected %0d actual %0d", $time,
                             want.end_of_row, got.end_of_row);
                    error_count++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_bytes.size() > 0 || in_valid || expected_calls.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_coverage(logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        min_cov = v;
    endtask

    initial begin
        logic [15:0] settings[5];
        error_count = 0;
        idle_cycles = 0;
        calm = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = 0;
        in_valid = 0;
        text_byte = 0;
        out_ready = 0;
        reset_caller();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed records: header, masking, DP and AD paths, colon mismatch, saturation.
        put_text("##meta\n#CHROM\n");
        put_text("c\t1\t.\tA\tC\t.\t.\t.\tGT:AD:DP\t0/1:12,11:30\t0/1:3,25:8\t.:.:.\n");
        put_text("c\t2\t.\tG\t.\t.\t.\t.\tDP\t25\t12\t9\t99999999\n");
        put_text("c\t3\t.\tAC\tG\t.\t.\t.\tDP\t40\n");
        put_text("c\t4\t.\tT\tGA\t.\t.\t.\tDP\t40\n");
        put_text("c\t5\t.\tN\tA\t.\t.\t.\tDP\t40\n");
        put_text("c\t6\t.\tT\t\t.\t.\t.\tAD\t30,30\t\n");
        put_text("c\t7\t.\tC\tT\t.\t.\t.\tAD:DP:AD\t1:x:40,2,9\t:\t1:2\n");
        put_text({"c\t8\t.\tC\tT\t.\t.\t.\tA:B:C:D:E:F:G:H:I:J:K:L:M:N:O:P:DP\t",
                  "1:2:3:4:5:6:7:8:9:10:11:12:13:14:15:16:17:18\n"});
        put_text({"\xff\x00\t\t\t\x80\t\t\t\t\t\t\x7f\n"});
        drain();

        settings = '{16'd0, 16'hFFFF, 16'd1, 16'd20, MIN_COVERAGE_RESET};
        for (int ph = 0; ph < 5; ph++) begin
            write_coverage(settings[ph]);
            calm = (ph == 2);
            while (pending_bytes.size() < 140)
                put_record();
            drain();
        end

        if (error_count == 0)
            $display("vcf_genotype_allele_caller_top regression: pass");
        else
            $display("vcf_genotype_allele_caller_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/vcf_gac_pkg.sv
hw/rtl/vcf_genotype_allele_caller_top.sv
bench/vcf_genotype_allele_caller_top_tb.sv
